// ----- hdl/rfc_pkg.sv -----
package rfc_pkg;

    localparam logic [7:0] CH_ACK   = 8'h06;
    localparam logic [7:0] CH_NAK   = 8'h15;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_SPACE = 8'h20;

    localparam int          HDR_LEN       = 6;
    localparam int          WIN_LEN       = 4;
    localparam logic [3:0]  CNT_MAX       = 4'd15;
    localparam logic [3:0]  MIN_FRAME     = 4'd8;
    localparam logic [3:0]  MIN_CMD_FRAME = 4'd9;
    localparam logic [3:0]  MIN_CODE_LEN  = 4'd10;
    localparam logic signed [7:0] ADDR_MIN = 8'sd1;
    localparam logic signed [7:0] ADDR_MAX = 8'sd16;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_BAD_FRAME = 3'd1;
    localparam logic [2:0] ST_BAD_ADDR  = 3'd2;
    localparam logic [2:0] ST_BAD_HEX   = 3'd3;
    localparam logic [2:0] ST_MISMATCH  = 3'd4;
    localparam logic [2:0] ST_SHORT     = 3'd5;

    typedef struct packed {
        logic              ok;
        logic signed [7:0] val;
    } t_num;

    typedef struct packed {
        logic       ok;
        logic [3:0] val;
    } t_hex;

    // Frame state captured on the last byte, then evaluated from this snapshot
    typedef struct packed {
        logic [3:0]  count;
        logic        hash;
        logic [7:0]  hdr1;
        logic [7:0]  hdr2;
        logic [7:0]  hdr3;
        logic [7:0]  hdr4;
        logic [7:0]  hdr5;
        logic [7:0]  win0;
        logic [7:0]  win1;
        logic [7:0]  win2;
        logic [7:0]  win3;
        logic [15:0] sum;
    } t_snap;

    typedef struct packed {
        logic [2:0]        status;
        logic [4:0]        station_address;
        logic              is_control;
        logic              acknowledged;
        logic signed [7:0] reply_error_code;
        logic [7:0]        command_first;
        logic [7:0]        command_second;
        logic [15:0]       computed_sum;
        logic [15:0]       supplied_sum;
    } t_result;

    function automatic logic is_ws(input logic [7:0] c);
        return (c == CH_SPACE) || (c >= 8'h09 && c <= 8'h0D);
    endfunction

    function automatic logic is_dig(input logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    function automatic t_hex hex_nib(input logic [7:0] c);
        t_hex r;
        r.ok  = 1'b1;
        r.val = 4'd0;
        if (is_dig(c)) begin
            r.val = c[3:0];
        end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
            r.val = 4'(c[2:0] + 3'd1) + 4'd8;
        end else begin
            r.ok = 1'b0;
        end
        return r;
    endfunction

    // Two characters, whitespace trimmed, as a signed decimal
    function automatic t_num parse_two(input logic [7:0] a, input logic [7:0] b);
        t_num       r;
        logic [7:0] s0;
        logic [7:0] s1;
        logic       two;
        logic [7:0] mag;
        logic       neg;
        r.ok  = 1'b0;
        r.val = '0;
        s0    = b;
        s1    = b;
        two   = 1'b0;
        mag   = 8'd0;
        neg   = 1'b0;
        if (!is_ws(a)) begin
            s0  = a;
            two = !is_ws(b);
        end
        if (is_ws(a) && is_ws(b)) begin
            r.ok = 1'b0;
        end else if (two) begin
            if (s0 == CH_PLUS || s0 == CH_MINUS) begin
                r.ok = is_dig(s1);
                neg  = (s0 == CH_MINUS);
                mag  = {4'd0, s1[3:0]};
            end else begin
                r.ok = is_dig(s0) && is_dig(s1);
                mag  = 8'({4'd0, s0[3:0]} * 8'd10) + {4'd0, s1[3:0]};
            end
        end else begin
            r.ok = is_dig(s0);
            mag  = {4'd0, s0[3:0]};
        end
        r.val = neg ? 8'(-mag) : mag;
        if (!r.ok) begin
            r.val = '0;
        end
        return r;
    endfunction

    function automatic logic [7:0] kind_byte(input logic is_cr);
        return is_cr ? CH_CR : CH_LF;
    endfunction

endpackage

// ----- hdl/rfc_channels.sv -----
interface rfc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    logic       frame_end;

    modport source(output valid, rx_byte, frame_end, input ready);
    modport sink(input valid, rx_byte, frame_end, output ready);
endinterface

interface rfc_out_if;
    logic              valid;
    logic              ready;
    logic [2:0]        status;
    logic [4:0]        station_address;
    logic              is_control;
    logic              acknowledged;
    logic signed [7:0] reply_error_code;
    logic [7:0]        command_first;
    logic [7:0]        command_second;
    logic [15:0]       computed_sum;
    logic [15:0]       supplied_sum;

    modport source(output valid, status, station_address, is_control, acknowledged,
                   reply_error_code, command_first, command_second, computed_sum,
                   supplied_sum, input ready);
    modport sink(input valid, status, station_address, is_control, acknowledged,
                 reply_error_code, command_first, command_second, computed_sum,
                 supplied_sum, output ready);
endinterface

// ----- hdl/rga_response_frame_checker.sv -----
// Response frame checker.
// i_in carries one received character per transaction (rx_byte) with frame_end
// set on the last character of a frame. o_out carries one checked result per
// frame: status, station address, control/ack flags, error code, command bytes
// and both checksums.
// Throughput: one character per clock cycle while i_in.ready is high; the per-character
// update of the sums, tail window and header bytes is a single registered pass.
// The edge that accepts the frame_end transaction captures the frame state in the
// snapshot register; o_out.valid rises when the evaluated result is loaded into
// the output register, which happens once the output register is free.
// Characters of the next frame are taken while the previous result waits.
// When o_out stalls, the output register holds its result and one captured
// frame may wait behind it; i_in drops ready while that captured frame waits,
// so nothing is lost.
// Reset clears all frame state and both valid flags; the block then waits for
// the first character of a new frame.
module rga_response_frame_checker (
    input  logic            i_clk,
    input  logic            i_rst_n,
    rfc_in_if.sink          i_in,
    rfc_out_if.source       o_out
);

    logic [3:0]  r_ccount, n_ccount;
    logic [3:0]  r_pcount, n_pcount;
    logic [3:0]  r_pkinds, n_pkinds;
    logic [15:0] r_psum, n_psum;
    logic [15:0] r_run, n_run;
    logic [7:0]  r_win [rfc_pkg::WIN_LEN];
    logic [7:0]  n_win [rfc_pkg::WIN_LEN];
    logic [7:0]  r_hdr [rfc_pkg::HDR_LEN];
    logic [7:0]  n_hdr [rfc_pkg::HDR_LEN];
    logic        r_hash, n_hash;

    rfc_pkg::t_snap   r_snap;
    logic             r_snap_valid;
    rfc_pkg::t_result r_res, n_res;
    logic             r_out_valid;

    logic        in_acc;
    logic        out_free;
    logic        snap_adv;
    logic [7:0]  b;
    logic [4:0]  pos;
    logic        is_crlf;
    logic [15:0] old_wsum;
    logic [15:0] new_wsum;
    logic [15:0] total;
    logic [4:0]  csum;

    assign out_free   = !r_out_valid || o_out.ready;
    assign snap_adv   = r_snap_valid && out_free;
    assign i_in.ready = !r_snap_valid || snap_adv;
    assign in_acc     = i_in.valid && i_in.ready;
    assign b          = i_in.rx_byte;

    // Per-character frame update
    always_comb begin
        pos      = {1'b0, r_ccount} + {1'b0, r_pcount};
        is_crlf  = (b == rfc_pkg::CH_CR) || (b == rfc_pkg::CH_LF);
        old_wsum = 16'(r_win[0]) + 16'(r_win[1]) + 16'(r_win[2]) + 16'(r_win[3]);
        total    = r_run + old_wsum + r_psum + 16'(b);
        csum     = {1'b0, r_ccount} + {1'b0, r_pcount} + 5'd1;

        for (int i = 0; i < rfc_pkg::HDR_LEN; i++) begin
            n_hdr[i] = (pos == 5'(i)) ? b : r_hdr[i];
        end

        n_ccount = r_ccount;
        n_pcount = r_pcount;
        n_pkinds = r_pkinds;
        n_psum   = r_psum;
        n_run    = r_run;
        n_hash   = r_hash;
        n_win    = r_win;
        new_wsum = old_wsum;

        if (is_crlf) begin
            n_pkinds = {b == rfc_pkg::CH_CR, r_pkinds[3:1]};
            n_psum   = r_psum + 16'(b);
            n_pcount = (r_pcount == rfc_pkg::CNT_MAX) ? rfc_pkg::CNT_MAX : r_pcount + 4'd1;
        end else begin
            // pending kinds: bit 3 is the newest held CR/LF, lower bits older ones
            case (r_pcount)
                4'd0: begin
                    n_win[0] = r_win[1];
                    n_win[1] = r_win[2];
                    n_win[2] = r_win[3];
                end
                4'd1: begin
                    n_win[0] = r_win[2];
                    n_win[1] = r_win[3];
                    n_win[2] = rfc_pkg::kind_byte(r_pkinds[3]);
                end
                4'd2: begin
                    n_win[0] = r_win[3];
                    n_win[1] = rfc_pkg::kind_byte(r_pkinds[2]);
                    n_win[2] = rfc_pkg::kind_byte(r_pkinds[3]);
                end
                default: begin
                    n_win[0] = rfc_pkg::kind_byte(r_pkinds[1]);
                    n_win[1] = rfc_pkg::kind_byte(r_pkinds[2]);
                    n_win[2] = rfc_pkg::kind_byte(r_pkinds[3]);
                end
            endcase
            n_win[3] = b;
            new_wsum = 16'(n_win[0]) + 16'(n_win[1]) + 16'(n_win[2]) + 16'(n_win[3]);
            n_run    = total - new_wsum;
            n_ccount = (csum > 5'(rfc_pkg::CNT_MAX)) ? rfc_pkg::CNT_MAX : csum[3:0];
            n_pcount = 4'd0;
            n_psum   = 16'd0;
            n_pkinds = 4'd0;
            n_hash   = (n_hdr[0] == rfc_pkg::CH_HASH);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ccount <= '0;
            r_pcount <= '0;
            r_pkinds <= '0;
            r_psum   <= '0;
            r_run    <= '0;
            r_hash   <= 1'b0;
            for (int i = 0; i < rfc_pkg::WIN_LEN; i++) r_win[i] <= '0;
            for (int i = 0; i < rfc_pkg::HDR_LEN; i++) r_hdr[i] <= '0;
        end else if (in_acc) begin
            if (i_in.frame_end) begin
                r_ccount <= '0;
                r_pcount <= '0;
                r_pkinds <= '0;
                r_psum   <= '0;
                r_run    <= '0;
                r_hash   <= 1'b0;
                for (int i = 0; i < rfc_pkg::WIN_LEN; i++) r_win[i] <= '0;
                for (int i = 0; i < rfc_pkg::HDR_LEN; i++) r_hdr[i] <= '0;
            end else begin
                r_ccount <= n_ccount;
                r_pcount <= n_pcount;
                r_pkinds <= n_pkinds;
                r_psum   <= n_psum;
                r_run    <= n_run;
                r_hash   <= n_hash;
                r_win    <= n_win;
                r_hdr    <= n_hdr;
            end
        end
    end

    // Capture the finished frame
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_snap_valid <= 1'b0;
        end else if (in_acc && i_in.frame_end) begin
            r_snap_valid <= 1'b1;
        end else if (snap_adv) begin
            r_snap_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && i_in.frame_end) begin
            r_snap.count <= n_ccount;
            r_snap.hash  <= n_hash;
            r_snap.hdr1  <= n_hdr[1];
            r_snap.hdr2  <= n_hdr[2];
            r_snap.hdr3  <= n_hdr[3];
            r_snap.hdr4  <= n_hdr[4];
            r_snap.hdr5  <= n_hdr[5];
            r_snap.win0  <= n_win[0];
            r_snap.win1  <= n_win[1];
            r_snap.win2  <= n_win[2];
            r_snap.win3  <= n_win[3];
            r_snap.sum   <= n_run;
        end
    end

    // Frame evaluation; first failed check sets the status
    rfc_pkg::t_num addr;
    rfc_pkg::t_num code;
    rfc_pkg::t_hex h0, h1, h2, h3;
    logic [15:0]   sup;
    logic          is_ctl;

    always_comb begin
        addr   = rfc_pkg::parse_two(r_snap.hdr1, r_snap.hdr2);
        code   = rfc_pkg::parse_two(r_snap.hdr4, r_snap.hdr5);
        h0     = rfc_pkg::hex_nib(r_snap.win0);
        h1     = rfc_pkg::hex_nib(r_snap.win1);
        h2     = rfc_pkg::hex_nib(r_snap.win2);
        h3     = rfc_pkg::hex_nib(r_snap.win3);
        sup    = {h0.val, h1.val, h2.val, h3.val};
        is_ctl = (r_snap.hdr3 == rfc_pkg::CH_ACK) || (r_snap.hdr3 == rfc_pkg::CH_NAK);
        n_res  = '0;

        if (r_snap.count < rfc_pkg::MIN_FRAME || !r_snap.hash) begin
            n_res.status = rfc_pkg::ST_BAD_FRAME;
        end else if (!addr.ok || addr.val < rfc_pkg::ADDR_MIN
                     || addr.val > rfc_pkg::ADDR_MAX) begin
            n_res.status = rfc_pkg::ST_BAD_ADDR;
        end else begin
            n_res.station_address = addr.val[4:0];
            if (!(h0.ok && h1.ok && h2.ok && h3.ok)) begin
                n_res.status = rfc_pkg::ST_BAD_HEX;
            end else begin
                n_res.computed_sum = r_snap.sum;
                n_res.supplied_sum = sup;
                if (r_snap.sum != sup) begin
                    n_res.status = rfc_pkg::ST_MISMATCH;
                end else if (is_ctl) begin
                    n_res.status        = rfc_pkg::ST_OK;
                    n_res.is_control    = 1'b1;
                    n_res.acknowledged  = (r_snap.hdr3 == rfc_pkg::CH_ACK);
                    n_res.command_first = r_snap.hdr3;
                    if (r_snap.count >= rfc_pkg::MIN_CODE_LEN && code.ok) begin
                        n_res.reply_error_code = code.val;
                    end
                end else if (r_snap.count < rfc_pkg::MIN_CMD_FRAME) begin
                    n_res.status = rfc_pkg::ST_SHORT;
                end else begin
                    n_res.status         = rfc_pkg::ST_OK;
                    n_res.command_first  = r_snap.hdr3;
                    n_res.command_second = r_snap.hdr4;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (snap_adv) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (snap_adv) begin
            r_res <= n_res;
        end
    end

    assign o_out.valid            = r_out_valid;
    assign o_out.status           = r_res.status;
    assign o_out.station_address  = r_res.station_address;
    assign o_out.is_control       = r_res.is_control;
    assign o_out.acknowledged     = r_res.acknowledged;
    assign o_out.reply_error_code = r_res.reply_error_code;
    assign o_out.command_first    = r_res.command_first;
    assign o_out.command_second   = r_res.command_second;
    assign o_out.computed_sum     = r_res.computed_sum;
    assign o_out.supplied_sum     = r_res.supplied_sum;

endmodule

// ----- tb/rga_response_frame_checker_test.sv -----
`timescale 1ns / 100ps

module rga_response_frame_checker_test;

    typedef enum int {REPLY_COMMAND, REPLY_CONTROL} t_reply_kind;
    typedef enum int {
        FLAW_NONE, FLAW_NO_HASH, FLAW_ADDRESS, FLAW_HEX_TEXT, FLAW_SUM, FLAW_SHORT
    } t_flaw;

    localparam logic [7:0] CH_ZERO = 8'h30;

    logic i_clk;
    logic i_rst_n;

    rfc_in_if  in_if ();
    rfc_out_if out_if ();

    rga_response_frame_checker u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    // Predicted frame state
    logic [3:0]  kept_cnt;
    logic [3:0]  held_cnt;
    logic        held_is_cr [4];
    logic [15:0] held_sum;
    logic [15:0] older_sum;
    logic [7:0]  tail_chars [4];
    logic [7:0]  head_chars [6];
    logic        hash_seen;

    rfc_pkg::t_result expected_verdicts [$];
    logic [7:0]  frame_chars [$];
    int          mismatch_count = 0;
    bit          src_idle_en = 1'b0;
    bit          sink_idle_en = 1'b0;
    int          sink_hold_cycles = 0;

    always begin
        i_clk = 1'b1;
        #2;
        i_clk = 1'b0;
        #2;
    end

    initial begin
        #2_000_000;
        $display("rga_response_frame_checker_test: FAIL");
        $finish;
    end

    // ---------------------------------------------------------------- prediction

    function automatic bit blank_char(logic [7:0] c);
        return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
    endfunction

    function automatic bit decimal_char(logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    function automatic int hex_value(logic [7:0] c);
        if (decimal_char(c)) return int'(c) - 'h30;
        if (c >= 8'h41 && c <= 8'h46) return int'(c) - 'h41 + 10;
        if (c >= 8'h61 && c <= 8'h66) return int'(c) - 'h61 + 10;
        return -1;
    endfunction

    // Trim whitespace, then an optional sign and one or two digits
    function automatic bit parse_pair(logic [7:0] a, logic [7:0] b, output int value);
        logic [7:0] txt [2];
        int         n = 0;
        int         i = 0;
        int         sign = 1;
        int         acc = 0;
        value = 0;
        if (!blank_char(a)) begin
            txt[0] = a;
            n = 1;
            if (!blank_char(b)) begin
                txt[1] = b;
                n = 2;
            end
        end else if (!blank_char(b)) begin
            txt[0] = b;
            n = 1;
        end
        if (n == 0) return 1'b0;
        if (txt[0] == rfc_pkg::CH_PLUS || txt[0] == rfc_pkg::CH_MINUS) begin
            if (txt[0] == rfc_pkg::CH_MINUS) sign = -1;
            i = 1;
        end
        if (i >= n) return 1'b0;
        while (i < n) begin
            if (!decimal_char(txt[i])) return 1'b0;
            acc = acc * 10 + int'(txt[i]) - 'h30;
            i++;
        end
        value = sign * acc;
        return 1'b1;
    endfunction

    function automatic logic [3:0] sat15(int v);
        return (v > int'(rfc_pkg::CNT_MAX)) ? rfc_pkg::CNT_MAX : 4'(v);
    endfunction

    function automatic void clear_tracker();
        kept_cnt  = '0;
        held_cnt  = '0;
        held_sum  = '0;
        older_sum = '0;
        hash_seen = 1'b0;
        foreach (held_is_cr[i]) held_is_cr[i] = 1'b0;
        foreach (tail_chars[i]) tail_chars[i] = '0;
        foreach (head_chars[i]) head_chars[i] = '0;
    endfunction

    function automatic void push_tail(logic [7:0] c);
        tail_chars[0] = tail_chars[1];
        tail_chars[1] = tail_chars[2];
        tail_chars[2] = tail_chars[3];
        tail_chars[3] = c;
    endfunction

    function automatic logic [15:0] tail_total();
        return 16'(tail_chars[0]) + 16'(tail_chars[1]) + 16'(tail_chars[2])
               + 16'(tail_chars[3]);
    endfunction

    function automatic void absorb_char(logic [7:0] c);
        int          pos;
        int          k;
        logic [15:0] total;
        pos = int'(kept_cnt) + int'(held_cnt);
        if (pos < 6) head_chars[pos] = c;
        if (c == rfc_pkg::CH_CR || c == rfc_pkg::CH_LF) begin
            // hold line endings until a later character proves they are data
            held_is_cr[0] = held_is_cr[1];
            held_is_cr[1] = held_is_cr[2];
            held_is_cr[2] = held_is_cr[3];
            held_is_cr[3] = (c == rfc_pkg::CH_CR);
            held_sum = held_sum + 16'(c);
            held_cnt = sat15(int'(held_cnt) + 1);
        end else begin
            total = 16'(older_sum + tail_total() + held_sum + 16'(c));
            k = (held_cnt < 3) ? int'(held_cnt) : 3;
            for (int i = 4 - k; i < 4; i++)
                push_tail(held_is_cr[i] ? rfc_pkg::CH_CR : rfc_pkg::CH_LF);
            push_tail(c);
            older_sum = 16'(total - tail_total());
            kept_cnt  = sat15(int'(kept_cnt) + int'(held_cnt) + 1);
            held_cnt  = '0;
            held_sum  = '0;
            foreach (held_is_cr[i]) held_is_cr[i] = 1'b0;
            hash_seen = (head_chars[0] == rfc_pkg::CH_HASH);
        end
    endfunction

    function automatic rfc_pkg::t_result judge_frame();
        rfc_pkg::t_result r;
        int               addr;
        int               code;
        int               nib;
        logic [15:0]      supplied;
        r = '0;
        r.status = rfc_pkg::ST_OK;
        supplied = 16'd0;
        if (kept_cnt < rfc_pkg::MIN_FRAME || !hash_seen) begin
            r.status = rfc_pkg::ST_BAD_FRAME;
            return r;
        end
        if (!parse_pair(head_chars[1], head_chars[2], addr) || addr < rfc_pkg::ADDR_MIN
                || addr > rfc_pkg::ADDR_MAX) begin
            r.status = rfc_pkg::ST_BAD_ADDR;
            return r;
        end
        r.station_address = 5'(addr);
        for (int i = 0; i < 4; i++) begin
            nib = hex_value(tail_chars[i]);
            if (nib < 0) begin
                r.status = rfc_pkg::ST_BAD_HEX;
                return r;
            end
            supplied = {supplied[11:0], 4'(nib)};
        end
        r.computed_sum = older_sum;
        r.supplied_sum = supplied;
        if (older_sum != supplied) begin
            r.status = rfc_pkg::ST_MISMATCH;
            return r;
        end
        if (head_chars[3] == rfc_pkg::CH_ACK || head_chars[3] == rfc_pkg::CH_NAK) begin
            r.is_control    = 1'b1;
            r.acknowledged  = (head_chars[3] == rfc_pkg::CH_ACK);
            r.command_first = head_chars[3];
            if (kept_cnt >= rfc_pkg::MIN_CODE_LEN
                    && parse_pair(head_chars[4], head_chars[5], code))
                r.reply_error_code = 8'(code);
            return r;
        end
        if (kept_cnt < rfc_pkg::MIN_CMD_FRAME) begin
            r.status = rfc_pkg::ST_SHORT;
            return r;
        end
        r.command_first  = head_chars[3];
        r.command_second = head_chars[4];
        return r;
    endfunction

    // ---------------------------------------------------------------- checking

    task automatic report_mismatch(input string what);
        $display("%0t ns mismatch: %s", $time, what);
        mismatch_count++;
    endtask

    task automatic check_field(input string name, input logic [15:0] got,
                               input logic [15:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %0h, want %0h", name, got, want));
    endtask

    always @(posedge i_clk) begin
        rfc_pkg::t_result want;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (expected_verdicts.size() == 0) begin
                report_mismatch("result with no frame awaiting it");
            end else begin
                want = expected_verdicts.pop_front();
                check_field("status", out_if.status, want.status);
                check_field("station_address", out_if.station_address, want.station_address);
                check_field("is_control", out_if.is_control, want.is_control);
                check_field("acknowledged", out_if.acknowledged, want.acknowledged);
                check_field("reply_error_code", out_if.reply_error_code,
                            want.reply_error_code);
                check_field("command_first", out_if.command_first, want.command_first);
                check_field("command_second", out_if.command_second, want.command_second);
                check_field("computed_sum", out_if.computed_sum, want.computed_sum);
                check_field("supplied_sum", out_if.supplied_sum, want.supplied_sum);
            end
        end
    end

    // Receiver: random stalls, plus a long hold-off when requested
    initial begin
        int stall_left;
        stall_left = 0;
        out_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (sink_hold_cycles > 0) begin
                sink_hold_cycles--;
                out_if.ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                out_if.ready <= 1'b0;
            end else if (sink_idle_en && $urandom_range(0, 4) == 0) begin
                stall_left = $urandom_range(0, 12);
                out_if.ready <= 1'b0;
            end else begin
                out_if.ready <= 1'b1;
            end
        end
    end

    // ---------------------------------------------------------------- stimulus

    function automatic void append_char(logic [7:0] c);
        frame_chars = {frame_chars, c};
    endfunction

    function automatic int pick_gap(bit en);
        if (!en || $urandom_range(0, 3) != 0) return 0;
        return $urandom_range(1, 13);
    endfunction

    task automatic send_char(input logic [7:0] c, input logic last);
        int gap;
        gap = pick_gap(src_idle_en);
        repeat (gap) begin
            @(negedge i_clk);
            in_if.valid <= 1'b0;
        end
        @(negedge i_clk);
        in_if.valid     <= 1'b1;
        in_if.rx_byte   <= c;
        in_if.frame_end <= last;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        absorb_char(c);
        if (last) begin
            expected_verdicts = {expected_verdicts, judge_frame()};
            clear_tracker();
        end
    endtask

    task automatic send_frame();
        foreach (frame_chars[i]) send_char(frame_chars[i], i == frame_chars.size() - 1);
    endtask

    task automatic input_idle();
        @(negedge i_clk);
        in_if.valid <= 1'b0;
    endtask

    task automatic wait_verdicts_drained();
        while (expected_verdicts.size() != 0) @(posedge i_clk);
    endtask

    function automatic logic [7:0] digit(int v);
        return CH_ZERO + 8'(v);
    endfunction

    function automatic logic [7:0] ws_char();
        return $urandom_range(0, 1) ? 8'h20 : 8'($urandom_range(9, 13));
    endfunction

    function automatic logic [7:0] param_char();
        case ($urandom_range(0, 7))
            0: return $urandom_range(0, 1) ? rfc_pkg::CH_CR : rfc_pkg::CH_LF;
            1: return 8'($urandom_range(0, 255));
            default: return 8'($urandom_range(8'h20, 8'h7E));
        endcase
    endfunction

    function automatic logic [7:0] hex_char(logic [3:0] nib);
        if (nib < 10) return CH_ZERO + 8'(nib);
        return 8'(($urandom_range(0, 1) ? 8'h41 : 8'h61) + nib - 10);
    endfunction

    function automatic logic [7:0] non_hex_char();
        logic [7:0] c;
        do c = 8'($urandom_range(0, 255)); while (hex_value(c) >= 0);
        return c;
    endfunction

    function automatic void pick_address(bit good, output logic [7:0] a, output logic [7:0] b);
        int v;
        v = $urandom_range(1, 16);
        a = digit(v / 10);
        b = digit(v % 10);
        if (good) begin
            if (v < 10) begin
                case ($urandom_range(0, 3))
                    1: a = ws_char();
                    2: begin a = digit(v); b = ws_char(); end
                    3: a = rfc_pkg::CH_PLUS;
                    default: ;
                endcase
            end
        end else begin
            case ($urandom_range(0, 4))
                0: begin a = CH_ZERO; b = CH_ZERO; end
                1: begin v = $urandom_range(17, 99); a = digit(v / 10); b = digit(v % 10); end
                2: begin a = ws_char(); b = ws_char(); end
                3: begin a = rfc_pkg::CH_MINUS; b = digit($urandom_range(1, 9)); end
                default: begin a = 8'($urandom_range(0, 255)); b = 8'($urandom_range(0, 255)); end
            endcase
        end
    endfunction

    function automatic void pick_code(output logic [7:0] a, output logic [7:0] b);
        int v;
        v = $urandom_range(0, 99);
        a = digit(v / 10);
        b = digit(v % 10);
        case ($urandom_range(0, 5))
            1: if (v < 10) a = ws_char();
            2: begin a = rfc_pkg::CH_MINUS; b = digit($urandom_range(0, 9)); end
            3: begin a = rfc_pkg::CH_PLUS; b = digit($urandom_range(0, 9)); end
            4: begin a = 8'($urandom_range(0, 255)); b = 8'($urandom_range(0, 255)); end
            5: begin a = digit(v % 10); b = ws_char(); end
            default: ;
        endcase
    endfunction

    // Append the four-digit hex checksum of the frame so far, optionally with a flipped bit or a non-hex digit
    function automatic void append_checksum(bit wrong_sum, bit bad_text);
        logic [15:0] total;
        int          spoil;
        total = 16'd0;
        foreach (frame_chars[i]) total = total + 16'(frame_chars[i]);
        if (wrong_sum) total = total ^ 16'(1 << $urandom_range(0, 15));
        spoil = bad_text ? $urandom_range(0, 3) : -1;
        for (int k = 3; k >= 0; k--) begin
            if (3 - k == spoil) append_char(non_hex_char());
            else append_char(hex_char(total[4*k +: 4]));
        end
    endfunction

    function automatic void build_frame(t_reply_kind kind, t_flaw flaw, int max_params);
        logic [7:0] a;
        logic [7:0] b;
        int         n_end;
        frame_chars.delete();
        if (flaw == FLAW_NO_HASH) begin
            a = 8'($urandom_range(0, 255));
            append_char(a == rfc_pkg::CH_HASH ? 8'h24 : a);
        end else begin
            append_char(rfc_pkg::CH_HASH);
        end
        pick_address(flaw != FLAW_ADDRESS, a, b);
        append_char(a);
        append_char(b);
        if (kind == REPLY_CONTROL) begin
            append_char($urandom_range(0, 1) ? rfc_pkg::CH_ACK : rfc_pkg::CH_NAK);
            if (flaw == FLAW_SHORT) begin
                // too few characters to carry an error code
                if ($urandom_range(0, 1)) append_char(param_char());
            end else begin
                pick_code(a, b);
                append_char(a);
                append_char(b);
            end
        end else begin
            append_char(8'($urandom_range(0, 255)));
            if (flaw != FLAW_SHORT) append_char(8'($urandom_range(0, 255)));
        end
        if (flaw != FLAW_SHORT)
            repeat ($urandom_range(0, max_params)) append_char(param_char());
        append_checksum(flaw == FLAW_SUM, flaw == FLAW_HEX_TEXT);
        n_end = ($urandom_range(0, 5) == 0) ? $urandom_range(4, 7) : $urandom_range(0, 2);
        repeat (n_end) append_char($urandom_range(0, 1) ? rfc_pkg::CH_CR : rfc_pkg::CH_LF);
    endfunction

    function automatic void build_noise(int len);
        frame_chars.delete();
        repeat (len) append_char(8'($urandom_range(0, 255)));
    endfunction

    function automatic void build_random_frame(int noise_weight, int max_params);
        if ($urandom_range(0, 9) < noise_weight)
            build_noise($urandom_range(1, 12));
        else
            build_frame(t_reply_kind'($urandom_range(0, 1)), t_flaw'($urandom_range(0, 5)),
                        max_params);
    endfunction

    // ---------------------------------------------------------------- tests

    task automatic test_lone_extremes();
        send_char(8'h00, 1'b1);
        send_char(8'hFF, 1'b1);
    endtask

    task automatic test_control_reply();
        frame_chars = {rfc_pkg::CH_HASH, rfc_pkg::CH_SPACE, 8'h37, rfc_pkg::CH_ACK,
                       rfc_pkg::CH_MINUS, 8'h33};
        append_checksum(1'b0, 1'b0);
        append_char(rfc_pkg::CH_CR);
        append_char(rfc_pkg::CH_LF);
        send_frame();
    endtask

    // A CR inside the body is held, then committed by the next character
    task automatic test_command_reply();
        frame_chars = {rfc_pkg::CH_HASH, 8'h31, 8'h36, 8'h52, rfc_pkg::CH_CR, 8'h76};
        append_checksum(1'b0, 1'b0);
        append_char(rfc_pkg::CH_LF);
        send_frame();
    endtask

    task automatic test_well_formed_frames(input int frames);
        src_idle_en  = 1'b1;
        sink_idle_en = 1'b1;
        repeat (frames) begin
            if ($urandom_range(0, 7) == 0)
                build_random_frame(0, 6);
            else
                build_frame(t_reply_kind'($urandom_range(0, 1)), FLAW_NONE, 6);
            send_frame();
        end
    endtask

    task automatic test_flawed_frames(input int frames);
        repeat (frames) begin
            build_random_frame(2, 6);
            send_frame();
        end
    endtask

    // Push the counters past saturation
    task automatic test_long_frames(input int frames);
        repeat (frames) begin
            build_frame(t_reply_kind'($urandom_range(0, 1)),
                        ($urandom_range(0, 3) == 0) ? t_flaw'($urandom_range(0, 5)) : FLAW_NONE,
                        24);
            send_frame();
        end
    endtask

    // Receiver holds off while frames keep coming: the block must stall its input
    task automatic test_output_hold();
        src_idle_en  = 1'b0;
        sink_idle_en = 1'b0;
        input_idle();
        wait_verdicts_drained();
        sink_hold_cycles = 120;
        repeat (8) begin
            build_frame(t_reply_kind'($urandom_range(0, 1)), FLAW_NONE, 2);
            send_frame();
        end
        input_idle();
        wait_verdicts_drained();
    endtask

    task automatic test_drain_pause();
        src_idle_en  = 1'b1;
        sink_idle_en = 1'b1;
        repeat (3) begin
            repeat ($urandom_range(1, 4)) begin
                build_random_frame(1, 6);
                send_frame();
            end
            input_idle();
            wait_verdicts_drained();
        end
    endtask

    task automatic test_full_rate(input int frames);
        src_idle_en  = 1'b0;
        sink_idle_en = 1'b0;
        repeat (frames) begin
            build_random_frame(1, 6);
            send_frame();
        end
    endtask

    initial begin
        i_rst_n         = 1'b0;
        in_if.valid     = 1'b0;
        in_if.rx_byte   = 8'h00;
        in_if.frame_end = 1'b0;
        clear_tracker();
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_lone_extremes();
        test_control_reply();
        test_command_reply();
        test_well_formed_frames(18);
        test_flawed_frames(14);
        test_long_frames(5);
        test_output_hold();
        test_drain_pause();
        test_full_rate(8);

        input_idle();
        wait_verdicts_drained();
        repeat (10) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("rga_response_frame_checker_test: PASS");
        end else begin
            $display("rga_response_frame_checker_test: FAIL");
        end
        $finish;
    end

endmodule
